[rtl/dhf_pkg.sv]
// ---------------------------------------------------------------------------
// dhf_pkg
// Shared widths, register indexes and types for the depth hole fill filter.
// ---------------------------------------------------------------------------
package dhf_pkg;

   localparam int PIX_W          = 16;
   localparam int WS_W           = 3;
   localparam int DIM_W          = 11;
   localparam int ROW_W          = 12;
   localparam int IDX_W          = 23;
   localparam int RAD_W          = 2;
   localparam int STEP_W         = RAD_W + 1;
   localparam int CNT_W          = 6;
   localparam int SUM_W          = 22;
   localparam int RING_IDX_W     = 5;
   localparam int CSR_IDX_W      = 2;
   localparam int MAX_WIDTH_DEF  = 1024;
   localparam int MAX_WINDOW_DEF = 7;

   // input row counter stops here
   localparam logic [ROW_W-1:0] ROW_CAP = 12'd4095;

   localparam logic [CSR_IDX_W-1:0] REG_WINDOW_SIZE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

   localparam logic [WS_W-1:0]  WINDOW_SIZE_RST  = 3'd3;
   localparam logic [DIM_W-1:0] IMAGE_WIDTH_RST  = 11'd640;
   localparam logic [DIM_W-1:0] IMAGE_HEIGHT_RST = 11'd480;

   // effective geometry after clamping
   typedef struct packed {
      logic [DIM_W-1:0] width;
      logic [DIM_W-1:0] height;
      logic [RAD_W-1:0] radius;
   } geom_type;

   // one word from front to back: a row store write and maybe a fill job
   typedef struct packed {
      logic [RING_IDX_W-1:0] wr_ring;
      logic [DIM_W-1:0]      wr_col;
      logic [PIX_W-1:0]      wr_data;
      logic                  job;
      logic [RING_IDX_W-1:0] ctr_ring;
      logic [DIM_W-1:0]      ctr_row;
      logic [DIM_W-1:0]      ctr_col;
      logic                  last;
   } qent_type;

endpackage

[rtl/dhf_ram.sv]
// ---------------------------------------------------------------------------
// dhf_ram
// Generic simple dual port ram, one write and one registered read port.
// ---------------------------------------------------------------------------
module dhf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/dhf_queue.sv]
// ---------------------------------------------------------------------------
// dhf_queue
// Two entry queue between the front and the back.
// ---------------------------------------------------------------------------
module dhf_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  dhf_pkg::qent_type push_data,
   input  logic              pop,
   output dhf_pkg::qent_type pop_data,
   output logic              empty,
   output logic              full
);

   dhf_pkg::qent_type ent_ff [2];
   logic              wp_ff, wp_in;
   logic              rp_ff, rp_in;
   logic [1:0]        cnt_ff, cnt_in;

   always_comb begin
      wp_in  = push ? ~wp_ff : wp_ff;
      rp_in  = pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wp_ff] <= push_data;
      end
   end

   assign pop_data = ent_ff[rp_ff];
   assign empty    = (cnt_ff == 2'd0);
   assign full     = (cnt_ff == 2'd2);

endmodule

[rtl/dhf_front.sv]
// ---------------------------------------------------------------------------
// dhf_front
// Accepts pixels, tracks input and output positions, decides which word
// carries a fill job and hands words to the queue.
// ---------------------------------------------------------------------------
module dhf_front #(
   parameter int MAX_WINDOW = dhf_pkg::MAX_WINDOW_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  dhf_pkg::geom_type         geom,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [dhf_pkg::PIX_W-1:0] req_depth_pixel,
   input  logic                      req_frame_start,
   input  logic                      req_padding,
   input  logic                      q_full,
   input  logic                      clr_busy,
   output logic                      q_push,
   output dhf_pkg::qent_type         q_data
);

   localparam int RING_ROWS = 2 * MAX_WINDOW + 2;
   localparam int RW        = dhf_pkg::RING_IDX_W + 1;
   localparam int RSTEP_W   = $clog2(dhf_pkg::IDX_W);
   localparam logic [dhf_pkg::RING_IDX_W-1:0] RING_LAST =
      dhf_pkg::RING_IDX_W'(RING_ROWS - 1);
   localparam logic [RW-1:0]      RING_N     = RW'(RING_ROWS);
   localparam logic [RSTEP_W-1:0] RSTEP_LAST = RSTEP_W'(dhf_pkg::IDX_W - 1);

   logic [dhf_pkg::DIM_W-1:0]      col_ff, col_in, c_col;
   logic [dhf_pkg::ROW_W-1:0]      row_ff, row_in, c_row;
   logic [dhf_pkg::RING_IDX_W-1:0] ring_ff, ring_in, c_ring;
   logic [dhf_pkg::DIM_W-1:0]      ocol_ff, ocol_in, c_ocol;
   logic [dhf_pkg::DIM_W-1:0]      orow_ff, orow_in, c_orow;
   logic [dhf_pkg::RING_IDX_W-1:0] oring_ff, oring_in, c_oring;
   logic [dhf_pkg::IDX_W-1:0]      oidx_ff, oidx_in, c_oidx;
   logic [dhf_pkg::DIM_W-1:0]      owidth_ff, owidth_in;
   logic                           rbusy_ff, rbusy_in;
   logic [RSTEP_W-1:0]             rstep_ff, rstep_in;
   logic [dhf_pkg::IDX_W-1:0]      rquo_ff, rquo_in;
   logic [dhf_pkg::DIM_W-1:0]      rrem_ff, rrem_in;
   logic [dhf_pkg::RING_IDX_W-1:0] rring_ff, rring_in;
   logic [dhf_pkg::DIM_W:0]        rsh;
   logic                           rge;
   logic [RW-1:0]                  rring2;
   logic [dhf_pkg::IDX_W-1:0]      delay, total, idx;
   logic [dhf_pkg::DIM_W-1:0]      w_last;
   logic                           start, job, accept, regeom;

   always_comb begin
      delay  = dhf_pkg::IDX_W'(geom.radius) * dhf_pkg::IDX_W'(geom.width)
             + dhf_pkg::IDX_W'(geom.radius);
      total  = dhf_pkg::IDX_W'(geom.width) * dhf_pkg::IDX_W'(geom.height);
      w_last = geom.width - dhf_pkg::DIM_W'(1);
      regeom = (geom.width != owidth_ff);

      req_stall = q_full | clr_busy | rbusy_ff | regeom;
      accept    = req_valid & ~req_stall;
      start     = req_frame_start & ~req_padding;

      c_col   = start ? '0 : col_ff;
      c_row   = start ? '0 : row_ff;
      c_ring  = start ? '0 : ring_ff;
      c_ocol  = start ? '0 : ocol_ff;
      c_orow  = start ? '0 : orow_ff;
      c_oring = start ? '0 : oring_ff;
      c_oidx  = start ? '0 : oidx_ff;

      idx = dhf_pkg::IDX_W'(c_row) * dhf_pkg::IDX_W'(geom.width)
          + dhf_pkg::IDX_W'(c_col);
      job = (idx >= delay) && (c_oidx < total);

      q_push          = accept;
      q_data.wr_ring  = c_ring;
      q_data.wr_col   = c_col;
      q_data.wr_data  = req_padding ? '0 : req_depth_pixel;
      q_data.job      = job;
      q_data.ctr_ring = c_oring;
      q_data.ctr_row  = c_orow;
      q_data.ctr_col  = c_ocol;
      q_data.last     = (c_oidx == total - dhf_pkg::IDX_W'(1));

      col_in   = col_ff;
      row_in   = row_ff;
      ring_in  = ring_ff;
      ocol_in  = ocol_ff;
      orow_in  = orow_ff;
      oring_in = oring_ff;
      oidx_in  = oidx_ff;
      if (accept) begin
         if (c_col >= w_last) begin
            col_in = '0;
            if (c_row != dhf_pkg::ROW_CAP) begin
               row_in  = c_row + dhf_pkg::ROW_W'(1);
               ring_in = (c_ring == RING_LAST) ? '0 : c_ring + dhf_pkg::RING_IDX_W'(1);
            end else begin
               row_in  = c_row;
               ring_in = c_ring;
            end
         end else begin
            col_in  = c_col + dhf_pkg::DIM_W'(1);
            row_in  = c_row;
            ring_in = c_ring;
         end
         oidx_in  = c_oidx;
         ocol_in  = c_ocol;
         orow_in  = c_orow;
         oring_in = c_oring;
         if (job) begin
            oidx_in = c_oidx + dhf_pkg::IDX_W'(1);
            if (c_ocol == w_last) begin
               ocol_in  = '0;
               orow_in  = c_orow + dhf_pkg::DIM_W'(1);
               oring_in = (c_oring == RING_LAST) ? '0
                        : c_oring + dhf_pkg::RING_IDX_W'(1);
            end else begin
               ocol_in = c_ocol + dhf_pkg::DIM_W'(1);
            end
         end
      end

      // width change: split the output index into row, column and ring again
      rsh    = {rrem_ff, rquo_ff[dhf_pkg::IDX_W-1]};
      rge    = (rsh >= {1'b0, geom.width});
      rring2 = {rring_ff, rge};
      if (rring2 >= RING_N) begin
         rring2 = rring2 - RING_N;
      end
      owidth_in = owidth_ff;
      rbusy_in  = rbusy_ff;
      rstep_in  = rstep_ff;
      rquo_in   = rquo_ff;
      rrem_in   = rrem_ff;
      rring_in  = rring_ff;
      if (regeom) begin
         owidth_in = geom.width;
         rbusy_in  = 1'b1;
         rstep_in  = '0;
         rquo_in   = oidx_ff;
         rrem_in   = '0;
         rring_in  = '0;
      end else if (rbusy_ff) begin
         rrem_in  = rge ? dhf_pkg::DIM_W'(rsh - {1'b0, geom.width})
                        : dhf_pkg::DIM_W'(rsh);
         rquo_in  = {rquo_ff[dhf_pkg::IDX_W-2:0], rge};
         rring_in = dhf_pkg::RING_IDX_W'(rring2);
         rstep_in = rstep_ff + RSTEP_W'(1);
         if (rstep_ff == RSTEP_LAST) begin
            rbusy_in = 1'b0;
            ocol_in  = rrem_in;
            orow_in  = rquo_in[dhf_pkg::DIM_W-1:0];
            oring_in = rring_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff    <= '0;
         row_ff    <= '0;
         ring_ff   <= '0;
         ocol_ff   <= '0;
         orow_ff   <= '0;
         oring_ff  <= '0;
         oidx_ff   <= '0;
         owidth_ff <= dhf_pkg::IMAGE_WIDTH_RST;
         rbusy_ff  <= 1'b0;
         rstep_ff  <= '0;
         rquo_ff   <= '0;
         rrem_ff   <= '0;
         rring_ff  <= '0;
      end else begin
         col_ff    <= col_in;
         row_ff    <= row_in;
         ring_ff   <= ring_in;
         ocol_ff   <= ocol_in;
         orow_ff   <= orow_in;
         oring_ff  <= oring_in;
         oidx_ff   <= oidx_in;
         owidth_ff <= owidth_in;
         rbusy_ff  <= rbusy_in;
         rstep_ff  <= rstep_in;
         rquo_ff   <= rquo_in;
         rrem_ff   <= rrem_in;
         rring_ff  <= rring_in;
      end
   end

endmodule

[rtl/dhf_back.sv]
// ---------------------------------------------------------------------------
// dhf_back
// Writes the row store, scans the window of each fill job one neighbour a
// cycle, divides the sum by the count bit by bit and holds the result.
// ---------------------------------------------------------------------------
module dhf_back #(
   parameter int MAX_WIDTH  = dhf_pkg::MAX_WIDTH_DEF,
   parameter int MAX_WINDOW = dhf_pkg::MAX_WINDOW_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  dhf_pkg::geom_type         geom,
   input  logic                      q_empty,
   input  dhf_pkg::qent_type         q_data,
   output logic                      q_pop,
   output logic                      clr_busy,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [dhf_pkg::PIX_W-1:0] rsp_filled_pixel,
   output logic                      rsp_frame_last
);

   localparam int RING_ROWS = 2 * MAX_WINDOW + 2;
   localparam int DEPTH     = RING_ROWS * MAX_WIDTH;
   localparam int ADDR_W    = $clog2(DEPTH);
   localparam int RW        = dhf_pkg::RING_IDX_W + 1;
   localparam int CW        = dhf_pkg::DIM_W + 1;
   localparam int DSTEP_W   = $clog2(dhf_pkg::SUM_W);
   localparam logic [ADDR_W-1:0]  ADDR_LAST  = ADDR_W'(DEPTH - 1);
   localparam logic [RW-1:0]      RING_N     = RW'(RING_ROWS);
   localparam logic [DSTEP_W-1:0] DSTEP_LAST = DSTEP_W'(dhf_pkg::SUM_W - 1);

   typedef enum logic [5:0] {
      ST_CLEAR = 6'b000001,
      ST_IDLE  = 6'b000010,
      ST_SCAN  = 6'b000100,
      ST_LAST  = 6'b001000,
      ST_DIV   = 6'b010000,
      ST_OUT   = 6'b100000
   } bstate_type;

   function automatic logic [ADDR_W-1:0] ring_addr(
      input logic [dhf_pkg::RING_IDX_W-1:0] ring,
      input logic [dhf_pkg::DIM_W-1:0]      col
   );
      ring_addr = ADDR_W'(ring) * ADDR_W'(MAX_WIDTH) + ADDR_W'(col);
   endfunction

   bstate_type                       state_ff, state_in;
   logic [ADDR_W-1:0]                clr_addr_ff, clr_addr_in;
   logic [dhf_pkg::RING_IDX_W-1:0]   ctr_ring_ff, ctr_ring_in;
   logic [dhf_pkg::DIM_W-1:0]        ctr_row_ff, ctr_row_in;
   logic [dhf_pkg::DIM_W-1:0]        ctr_col_ff, ctr_col_in;
   logic                             last_ff, last_in;
   logic [dhf_pkg::STEP_W-1:0]       i_ff, i_in, j_ff, j_in, span;
   logic                             rd_pend_ff, rd_pend_in;
   logic                             rd_use_ff, rd_use_in;
   logic                             rd_ctr_ff, rd_ctr_in;
   logic [dhf_pkg::SUM_W-1:0]        sum_ff, sum_in;
   logic [dhf_pkg::CNT_W-1:0]        cnt_ff, cnt_in;
   logic [dhf_pkg::PIX_W-1:0]        centre_ff, centre_in;
   logic [dhf_pkg::SUM_W-1:0]        quo_ff, quo_in;
   logic [dhf_pkg::CNT_W-1:0]        rem_ff, rem_in;
   logic [DSTEP_W-1:0]               dstep_ff, dstep_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [dhf_pkg::PIX_W-1:0]        rsp_pixel_ff, rsp_pixel_in;
   logic                             rsp_last_ff, rsp_last_in;

   logic                             wr_en;
   logic [ADDR_W-1:0]                wr_addr, rd_addr;
   logic [dhf_pkg::PIX_W-1:0]        wr_data, rd_data;
   logic [RW-1:0]                    t, u, rr;
   logic [CW-1:0]                    yv, xv, rc;
   logic                             y_ok, x_ok;
   logic [dhf_pkg::CNT_W:0]          sh;
   logic                             ge;

   dhf_ram #(
      .WIDTH (dhf_pkg::PIX_W),
      .DEPTH (DEPTH)
   ) u_row_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      ctr_ring_in  = ctr_ring_ff;
      ctr_row_in   = ctr_row_ff;
      ctr_col_in   = ctr_col_ff;
      last_in      = last_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      dstep_in     = dstep_ff;
      rsp_pixel_in = rsp_pixel_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      q_pop        = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = ring_addr(q_data.wr_ring, q_data.wr_col);
      wr_data      = q_data.wr_data;
      span         = dhf_pkg::STEP_W'({geom.radius, 1'b0});

      // neighbour position of the current scan step
      rr = RW'(geom.radius);
      rc = CW'(geom.radius);
      t  = RW'(ctr_ring_ff) + RW'(i_ff);
      if (t >= rr) begin
         u = t - rr;
         if (u >= RING_N) begin
            u = u - RING_N;
         end
      end else begin
         u = t + RING_N - rr;
      end
      yv      = CW'(ctr_row_ff) + CW'(i_ff);
      xv      = CW'(ctr_col_ff) + CW'(j_ff);
      y_ok    = (yv >= rc) && ((yv - rc) < CW'(geom.height));
      x_ok    = (xv >= rc) && ((xv - rc) < CW'(geom.width));
      rd_addr = ring_addr(dhf_pkg::RING_IDX_W'(u), dhf_pkg::DIM_W'(xv - rc));

      rd_pend_in = 1'b0;
      rd_use_in  = y_ok & x_ok;
      rd_ctr_in  = (i_ff == dhf_pkg::STEP_W'(geom.radius))
                 && (j_ff == dhf_pkg::STEP_W'(geom.radius));

      // accumulate the word read by the previous scan step
      sum_in    = sum_ff;
      cnt_in    = cnt_ff;
      centre_in = centre_ff;
      if (rd_pend_ff) begin
         if (rd_use_ff && (rd_data != '0)) begin
            sum_in = sum_ff + dhf_pkg::SUM_W'(rd_data);
            cnt_in = cnt_ff + dhf_pkg::CNT_W'(1);
         end
         if (rd_ctr_ff) begin
            centre_in = rd_data;
         end
      end

      sh = {rem_ff, quo_ff[dhf_pkg::SUM_W-1]};
      ge = (sh >= {1'b0, cnt_ff});

      case (state_ff)
         ST_CLEAR: begin
            wr_en       = 1'b1;
            wr_addr     = clr_addr_ff;
            wr_data     = '0;
            clr_addr_in = clr_addr_ff + ADDR_W'(1);
            if (clr_addr_ff == ADDR_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop = 1'b1;
               wr_en = 1'b1;
               if (q_data.job) begin
                  ctr_ring_in = q_data.ctr_ring;
                  ctr_row_in  = q_data.ctr_row;
                  ctr_col_in  = q_data.ctr_col;
                  last_in     = q_data.last;
                  i_in        = '0;
                  j_in        = '0;
                  sum_in      = '0;
                  cnt_in      = '0;
                  centre_in   = '0;
                  state_in    = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            rd_pend_in = 1'b1;
            if (j_ff == span) begin
               j_in = '0;
               i_in = i_ff + dhf_pkg::STEP_W'(1);
               if (i_ff == span) begin
                  state_in = ST_LAST;
               end
            end else begin
               j_in = j_ff + dhf_pkg::STEP_W'(1);
            end
         end
         ST_LAST: begin
            quo_in   = sum_in;
            rem_in   = '0;
            dstep_in = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            rem_in   = ge ? dhf_pkg::CNT_W'(sh - {1'b0, cnt_ff}) : dhf_pkg::CNT_W'(sh);
            quo_in   = {quo_ff[dhf_pkg::SUM_W-2:0], ge};
            dstep_in = dstep_ff + DSTEP_W'(1);
            if (dstep_ff == DSTEP_LAST) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = last_ff;
               if (centre_ff != '0) begin
                  rsp_pixel_in = centre_ff;
               end else if (cnt_ff == '0) begin
                  rsp_pixel_in = '0;
               end else begin
                  rsp_pixel_in = quo_ff[dhf_pkg::PIX_W-1:0];
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ctr_ring_ff  <= ctr_ring_in;
      ctr_row_ff   <= ctr_row_in;
      ctr_col_ff   <= ctr_col_in;
      last_ff      <= last_in;
      i_ff         <= i_in;
      j_ff         <= j_in;
      rd_use_ff    <= rd_use_in;
      rd_ctr_ff    <= rd_ctr_in;
      sum_ff       <= sum_in;
      cnt_ff       <= cnt_in;
      centre_ff    <= centre_in;
      quo_ff       <= quo_in;
      rem_ff       <= rem_in;
      dstep_ff     <= dstep_in;
      rsp_pixel_ff <= rsp_pixel_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign clr_busy         = (state_ff == ST_CLEAR);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_filled_pixel = rsp_pixel_ff;
   assign rsp_frame_last   = rsp_last_ff;

endmodule

[rtl/depth_hole_fill_mean_filter.sv]
// ---------------------------------------------------------------------------
// depth_hole_fill_mean_filter
// Fills zero depth pixels with the mean of the nonzero pixels around them.
// Output: the result for a pixel leaves with the word radius*width+radius
//   positions later, after the back has scanned its window and divided.
// Flow: a word with no fill job passes on; a job holds the back for the
//   window scan and divider; a width write stalls req while the index is split.
// Reset: zeroes all (2*MAX_WINDOW+2)*MAX_WIDTH words of the row store with
//   req_stall high; registers return to 3 / 640 / 480.
// ---------------------------------------------------------------------------
module depth_hole_fill_mean_filter #(
   parameter int MAX_WIDTH  = dhf_pkg::MAX_WIDTH_DEF,
   parameter int MAX_WINDOW = dhf_pkg::MAX_WINDOW_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [dhf_pkg::PIX_W-1:0]     req_depth_pixel,
   input  logic                          req_frame_start,
   input  logic                          req_padding,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [dhf_pkg::PIX_W-1:0]     rsp_filled_pixel,
   output logic                          rsp_frame_last,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [dhf_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [dhf_pkg::DIM_W-1:0]     csr_wdata
);

   logic [dhf_pkg::WS_W-1:0]  ws_ff, ws_in;
   logic [dhf_pkg::DIM_W-1:0] iw_ff, iw_in;
   logic [dhf_pkg::DIM_W-1:0] ih_ff, ih_in;
   logic [dhf_pkg::WS_W-1:0]  size;
   dhf_pkg::geom_type         geom;
   dhf_pkg::qent_type         push_data, pop_data;
   logic                      q_push, q_pop, q_empty, q_full, clr_busy;

   assign csr_ready = 1'b1;

   always_comb begin
      ws_in = ws_ff;
      iw_in = iw_ff;
      ih_in = ih_ff;
      if (csr_valid) begin
         case (csr_index)
            dhf_pkg::REG_WINDOW_SIZE:  ws_in = csr_wdata[dhf_pkg::WS_W-1:0];
            dhf_pkg::REG_IMAGE_WIDTH:  iw_in = csr_wdata;
            dhf_pkg::REG_IMAGE_HEIGHT: ih_in = csr_wdata;
            default: begin
            end
         endcase
      end

      // clamp to the supported geometry
      if (iw_ff == '0) begin
         geom.width = dhf_pkg::DIM_W'(1);
      end else if (32'(iw_ff) > MAX_WIDTH) begin
         geom.width = dhf_pkg::DIM_W'(MAX_WIDTH);
      end else begin
         geom.width = iw_ff;
      end
      geom.height = (ih_ff == '0) ? dhf_pkg::DIM_W'(1) : ih_ff;
      size        = (32'(ws_ff) > MAX_WINDOW) ? dhf_pkg::WS_W'(MAX_WINDOW) : ws_ff;
      geom.radius = size[dhf_pkg::WS_W-1:1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ws_ff <= dhf_pkg::WINDOW_SIZE_RST;
         iw_ff <= dhf_pkg::IMAGE_WIDTH_RST;
         ih_ff <= dhf_pkg::IMAGE_HEIGHT_RST;
      end else begin
         ws_ff <= ws_in;
         iw_ff <= iw_in;
         ih_ff <= ih_in;
      end
   end

   dhf_front #(
      .MAX_WINDOW (MAX_WINDOW)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .geom            (geom),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_depth_pixel (req_depth_pixel),
      .req_frame_start (req_frame_start),
      .req_padding     (req_padding),
      .q_full          (q_full),
      .clr_busy        (clr_busy),
      .q_push          (q_push),
      .q_data          (push_data)
   );

   dhf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_data),
      .pop       (q_pop),
      .pop_data  (pop_data),
      .empty     (q_empty),
      .full      (q_full)
   );

   dhf_back #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_WINDOW (MAX_WINDOW)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .geom             (geom),
      .q_empty          (q_empty),
      .q_data           (pop_data),
      .q_pop            (q_pop),
      .clr_busy         (clr_busy),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_filled_pixel (rsp_filled_pixel),
      .rsp_frame_last   (rsp_frame_last)
   );

endmodule
